/* rtl/core/coacc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association accumulator package
// Shared sizes, command and reply codes, and the types passed between the
// front end, the command queue and the matrix engine.
// ----------------------------------------------------------------------------
package coacc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DEPTH     = MAX_ITEMS * MAX_ITEMS;
    localparam int LABEL_W   = 16;
    localparam int ENTRY_W   = 32;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ITEMS_IN_USE = CFG_IDX_W'(1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);
    localparam logic [CNT_W-1:0]    DIM_RESET    = CNT_W'(MAX_ITEMS);

    // Input function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Reply kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Command opcodes carried by the queue
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_LAST = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [LABEL_W-1:0] label;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
    } t_cmd;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]    last_idx;
    } t_cfg;

endpackage : coacc_pkg
`default_nettype wire

/* rtl/core/coacc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association accumulator channels
// Input, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface coacc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] cluster_label;
    logic [5:0]  read_row;
    logic [5:0]  read_col;

    modport source (output valid, func, cluster_label, read_row, read_col, input ready);
    modport sink   (input valid, func, cluster_label, read_row, read_col, output ready);
endinterface : coacc_in_if

interface coacc_out_if;
    logic        valid;
    logic        ready;
    logic        reply_kind;
    logic [31:0] entry_value;

    modport source (output valid, reply_kind, entry_value, input ready);
    modport sink   (input valid, reply_kind, entry_value, output ready);
endinterface : coacc_out_if

interface coacc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface : coacc_cfg_if
`default_nettype wire

/* rtl/core/coacc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association accumulator front end
// Holds the configuration, counts labels and turns each input transfer into
// a queue command.
// ----------------------------------------------------------------------------
module coacc_front
    import coacc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_clearing,
    coacc_in_if.sink    i_in,
    coacc_cfg_if.sink   i_cfg,
    output t_cfg        o_cfg,
    output logic        o_push_valid,
    input  wire         i_push_ready,
    output t_cmd        o_push_cmd
);

    logic [WEIGHT_W-1:0] r_weight;
    logic [CNT_W-1:0]    r_items;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    dim;
    logic [CNT_W-1:0]    cnt_inc;
    logic                last;
    logic                in_xfer;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
            r_items  <= DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_MATCH_WEIGHT: r_weight <= i_cfg.wdata[WEIGHT_W-1:0];
                REG_ITEMS_IN_USE: r_items  <= i_cfg.wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the dimension into 1..MAX_ITEMS
    always_comb begin
        if (r_items == '0) begin
            dim = CNT_W'(1);
        end else if (r_items > CNT_W'(MAX_ITEMS)) begin
            dim = CNT_W'(MAX_ITEMS);
        end else begin
            dim = r_items;
        end
    end

    assign o_cfg.weight   = r_weight;
    assign o_cfg.last_idx = IDX_W'(dim - CNT_W'(1));

    assign i_in.ready   = !i_clearing && i_push_ready;
    assign in_xfer      = i_in.valid && i_in.ready;
    assign o_push_valid = i_in.valid && !i_clearing;

    assign cnt_inc = r_cnt + CNT_W'(1);
    assign last    = (cnt_inc >= dim);

    always_comb begin
        o_push_cmd.label = i_in.cluster_label;
        o_push_cmd.col   = i_in.read_col;
        if (i_in.func == FUNC_READ) begin
            o_push_cmd.op  = OP_READ;
            o_push_cmd.row = i_in.read_row;
        end else begin
            o_push_cmd.op  = last ? OP_LAST : OP_LOAD;
            o_push_cmd.row = r_cnt[IDX_W-1:0];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (in_xfer && i_in.func == FUNC_LOAD) begin
            n_cnt = last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule : coacc_front
`default_nettype wire

/* rtl/core/coacc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association accumulator command queue
// Small FIFO between the front end and the matrix engine.
// ----------------------------------------------------------------------------
module coacc_queue
    import coacc_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  wire       i_pop_ready,
    output t_cmd      o_pop_cmd
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;
    logic                push, pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : coacc_queue
`default_nettype wire

/* rtl/core/coacc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association accumulator matrix engine
// Stores labels and the matrix, sweeps the matrix after each labeling and
// serves entry reads through a registered result stage.
// ----------------------------------------------------------------------------
module coacc_back
    import coacc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire         i_pop_valid,
    output logic        o_pop_ready,
    input  wire t_cmd   i_pop_cmd,
    output logic        o_clearing,
    coacc_out_if.source o_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_ACK   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;

    logic [ENTRY_W-1:0] r_matrix [DEPTH];
    logic [LABEL_W-1:0] r_labels [MAX_ITEMS];

    logic [2:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [IDX_W-1:0]   r_row, r_col, n_row, n_col;
    logic               r_p1_valid, n_p1_valid;
    logic               r_p1_diag;
    logic [ADDR_W-1:0]  r_p1_addr;
    logic [ENTRY_W-1:0] r_mem_q;
    logic [LABEL_W-1:0] r_lbl_a, r_lbl_b;
    logic               r_out_valid;
    logic               r_out_kind;
    logic [ENTRY_W-1:0] r_out_value;

    logic               out_free;
    logic               pop;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               hit;
    logic [ENTRY_W:0]   sum;
    logic               load_ack, load_read;
    logic               sweep_end;

    assign o_clearing = (r_state == S_CLEAR);
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        o_pop_ready = 1'b0;
        if (r_state == S_IDLE) begin
            o_pop_ready = (i_pop_cmd.op != OP_READ) || out_free;
        end
    end
    assign pop = i_pop_valid && o_pop_ready;

    // Label store: written by load commands, read at row and column in sweep
    always_ff @(posedge i_clk) begin
        if (pop && i_pop_cmd.op != OP_READ) begin
            r_labels[i_pop_cmd.row] <= i_pop_cmd.label;
        end
        r_lbl_a <= r_labels[r_row];
        r_lbl_b <= r_labels[r_col];
    end

    // Matrix read address: sweep position, or the entry a read asks for
    assign rd_addr = (r_state == S_SWEEP) ? {r_row, r_col}
                                          : {i_pop_cmd.row, i_pop_cmd.col};

    // Second sweep stage: saturating add of the weight on a match
    assign hit = r_p1_diag || (r_lbl_a == r_lbl_b);
    assign sum = {1'b0, r_mem_q} + (ENTRY_W+1)'(i_cfg.weight);

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = r_p1_valid && hit;
            mem_waddr = r_p1_addr;
            mem_wdata = sum[ENTRY_W] ? '1 : sum[ENTRY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_matrix[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_matrix[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr <= {r_row, r_col};
        r_p1_diag <= (r_row == r_col);
    end

    assign sweep_end = (r_row == i_cfg.last_idx) && (r_col == i_cfg.last_idx);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_p1_valid = 1'b0;
        load_ack   = 1'b0;
        load_read  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (i_pop_cmd.op)
                        OP_LAST: begin
                            n_state = S_SWEEP;
                            n_row   = '0;
                            n_col   = '0;
                        end
                        OP_READ: n_state = S_READ;
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                n_p1_valid = 1'b1;
                if (sweep_end) begin
                    n_state = S_ACK;
                end else if (r_col == i_cfg.last_idx) begin
                    n_col = '0;
                    n_row = r_row + IDX_W'(1);
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end
            S_ACK: begin
                if (out_free) begin
                    load_ack = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_READ: begin
                load_read = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_p1_valid <= n_p1_valid;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ack || load_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ack) begin
            r_out_kind  <= KIND_ACK;
            r_out_value <= '0;
        end else if (load_read) begin
            r_out_kind  <= KIND_READ;
            r_out_value <= r_mem_q;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.reply_kind  = r_out_kind;
    assign o_out.entry_value = r_out_value;

endmodule : coacc_back
`default_nettype wire

/* rtl/core/coassociation_matrix_accumulator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Co-association matrix accumulator
// Accumulates weighted label co-occurrence counts in a 64 x 64 matrix.
// ----------------------------------------------------------------------------
// After reset the block zeroes the matrix (one entry a cycle) and takes no
// input transfer until that pass ends; configuration writes are taken at any
// time but must only be issued while idle. Each label transfer is queued when
// the queue has room. When the last label of a labeling (items_in_use of them)
// reaches the matrix engine, it sweeps all n x n entries of the active square
// through the matrix read and write ports, one entry a cycle, then returns the
// acknowledgement. A read transfer's entry is read into a read register as it
// leaves the queue, then into the result register. Up to four commands queue
// behind a sweep, so the input side keeps accepting while the engine or the
// result side stalls, until the queue is full.
// ----------------------------------------------------------------------------
module coassociation_matrix_accumulator
    import coacc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    coacc_in_if.sink    i_in,
    coacc_cfg_if.sink   i_cfg,
    coacc_out_if.source o_out
);

    t_cfg  cfg;
    t_cmd  push_cmd, pop_cmd;
    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    logic  clearing;

    // Front end: hold config, count labels, classify each transfer
    coacc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clearing   (clearing),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_cfg        (cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    // Decouple the front end from the matrix engine
    coacc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    // Matrix engine: store labels, sweep, serve reads, drive results
    coacc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule : coassociation_matrix_accumulator
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Co-association matrix accumulator testbench
// Loads labelings and reads matrix entries through the input channel, and
// sets the weight and dimension registers through the configuration channel.
// A scoreboard model in this file tracks the matrix. Each reply is checked
// against it in transfer order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import coacc_pkg::*;

    // Run control
    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 30000; // longest quiet stretch: one 64 x 64 sweep + stall
    localparam int DRAIN_CYCLES   = 64;    // settle time for queued loads with no reply
    localparam int PHASE_ITEMS    = 70;
    localparam int NUM_PHASES     = 8;
    localparam int HEAVY_LOADS    = 16;

    typedef struct {
        logic        kind;
        logic [31:0] value;
    } reply_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    coacc_in_if  in_ch ();
    coacc_cfg_if cfg_ch ();
    coacc_out_if out_ch ();

    coassociation_matrix_accumulator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scoreboard model of the matrix, the label buffer and the registers
    // ------------------------------------------------------------------------
    logic [31:0]         pair_sum [MAX_ITEMS][MAX_ITEMS];
    logic [LABEL_W-1:0]  label_hist [MAX_ITEMS];
    int                  labels_held;
    logic [WEIGHT_W-1:0] cur_weight;
    logic [6:0]          cur_dim;

    reply_t pending_replies[$];
    int     fail_count = 0;

    bit in_idle_on  = 1'b1;
    bit out_stall_on = 1'b1;
    int out_stall_left = 0;
    int quiet_cycles = 0;

    // Clamp the dimension register: zero acts as one, anything above the
    // matrix size acts as the matrix size.
    function automatic int active_dim();
        if (cur_dim == 0)
            return 1;
        if (cur_dim > MAX_ITEMS)
            return MAX_ITEMS;
        return int'(cur_dim);
    endfunction

    function automatic void add_weight(int r, int c);
        logic [32:0] s;
        s = {1'b0, pair_sum[r][c]} + 33'(cur_weight);
        pair_sum[r][c] = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Fold one finished labeling into the matrix: diagonal always, and both
    // mirror entries of every pair with equal labels.
    function automatic void fold_labeling(int n);
        for (int r = 0; r < n; r++) begin
            add_weight(r, r);
            for (int c = r + 1; c < n; c++) begin
                if (label_hist[r] == label_hist[c]) begin
                    add_weight(r, c);
                    add_weight(c, r);
                end
            end
        end
    endfunction

    // Advance the model by one accepted input transfer and queue its reply.
    function automatic void predict_transfer(logic func, logic [15:0] lab,
                                             logic [5:0] row, logic [5:0] col);
        reply_t rep;
        if (func == FUNC_READ) begin
            rep.kind  = KIND_READ;
            rep.value = pair_sum[row][col];
            pending_replies.push_back(rep);
        end else begin
            if (labels_held < MAX_ITEMS)
                label_hist[labels_held] = lab;
            labels_held++;
            if (labels_held >= active_dim()) begin
                fold_labeling(active_dim());
                labels_held = 0;
                rep.kind  = KIND_ACK;
                rep.value = '0;
                pending_replies.push_back(rep);
            end
        end
    endfunction

    function automatic void reset_model();
        for (int r = 0; r < MAX_ITEMS; r++) begin
            label_hist[r] = '0;
            for (int c = 0; c < MAX_ITEMS; c++)
                pair_sum[r][c] = '0;
        end
        labels_held = 0;
        cur_weight  = WEIGHT_RESET;
        cur_dim     = 7'(DIM_RESET);
    endfunction

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Reply side: random back-pressure at the falling edge, check at the
    // rising edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left = out_stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
            out_stall_left = pick_gap(1'b1);
            out_ch.ready <= (out_stall_left == 0);
            if (out_stall_left > 0)
                out_stall_left = out_stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply, kind %0b value %h", $time,
                         out_ch.reply_kind, out_ch.entry_value);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (out_ch.reply_kind !== want.kind) begin
                    $display("%0t: reply_kind mismatch, expected %0b actual %0b", $time,
                             want.kind, out_ch.reply_kind);
                    fail_count++;
                end
                if (out_ch.entry_value !== want.value) begin
                    $display("%0t: entry_value mismatch, expected %h actual %h", $time,
                             want.value, out_ch.entry_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: reset the count on any transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one input transfer. Valid stays high on return so a back-to-back
    // transfer needs only one update at the next falling edge.
    task automatic send_item(input logic func, input logic [15:0] lab,
                             input logic [5:0] row, input logic [5:0] col);
        int gap;
        gap = pick_gap(in_idle_on);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.func          <= func;
        in_ch.cluster_label <= lab;
        in_ch.read_row      <= row;
        in_ch.read_col      <= col;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_transfer(func, lab, row, col);
    endtask

    task automatic send_load(input logic [15:0] lab);
        send_item(FUNC_LOAD, lab, 6'($urandom), 6'($urandom));
    endtask

    task automatic send_read(input logic [5:0] row, input logic [5:0] col);
        send_item(FUNC_READ, 16'($urandom), row, col);
    endtask

    // Drop valid, wait for every pending reply, then let queued loads drain.
    task automatic quiesce();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_MATCH_WEIGHT)
            cur_weight = data;
        else if (idx == REG_ITEMS_IN_USE)
            cur_dim = data[6:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] weight, input logic [6:0] dim);
        write_reg(REG_MATCH_WEIGHT, weight);
        write_reg(REG_ITEMS_IN_USE, {9'b0, dim});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Matrix corners read as zero after the clearing pass.
    task automatic test_reset_state();
        send_read(6'd0, 6'd0);
        send_read(6'd63, 6'd63);
        send_read(6'd0, 6'd63);
        send_read(6'd63, 6'd0);
    endtask

    // Extreme weight, extreme labels; one matching off-diagonal pair.
    task automatic test_basic_labeling();
        quiesce();
        set_config(16'hFFFF, 7'd4);
        send_load(16'hFFFF);
        send_load(16'h0000);
        send_load(16'hFFFF);
        send_load(16'h1234);
        send_read(6'd0, 6'd2);
        send_read(6'd2, 6'd0);
        send_read(6'd0, 6'd1);
        send_read(6'd3, 6'd3);
        send_read(6'd63, 6'd63); // outside the active square, returned as stored
    endtask

    // Shrink the dimension to the count already loaded, then use zero.
    task automatic test_dim_change();
        quiesce();
        write_reg(REG_MATCH_WEIGHT, 16'h0180);
        send_load(16'h0007);
        send_load(16'h0007);
        quiesce();
        write_reg(REG_ITEMS_IN_USE, 16'd2);
        send_load(16'h0009);                 // completes, folding in the first two labels
        quiesce();
        write_reg(REG_ITEMS_IN_USE, 16'd0);  // acts as a dimension of one
        send_load(16'h0003);
        send_read(6'd0, 6'd1);
        send_read(6'd1, 6'd1);
        send_read(6'd0, 6'd0);
    endtask

    task automatic test_zero_weight();
        quiesce();
        set_config(16'h0000, 7'd3);
        send_load(16'h0005);
        send_load(16'h0005);
        send_load(16'h0005);
        send_read(6'd0, 6'd1);
    endtask

    // Random phases: mostly labels from a small pool so that pairs match,
    // some fully random labels, and reads spread over the whole matrix.
    task automatic test_random_labelings();
        logic [15:0] pool [4];
        logic [15:0] weight;
        logic [6:0]  dim;
        int          span;
        int          roll;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiesce();
            case (ph)
                0: begin
                    weight = 16'h0100;
                    dim    = 7'd64;
                end
                1: begin
                    weight = 16'($urandom);
                    dim    = 7'd127;
                end
                2: begin
                    weight = 16'h0000;
                    dim    = 7'd1;
                end
                3: begin
                    weight = 16'hFFFF;
                    dim    = 7'd2;
                end
                default: begin
                    weight = 16'($urandom);
                    dim    = 7'($urandom_range(1, 8));
                end
            endcase
            // Run one phase flat out on both sides.
            in_idle_on   = (ph != 4);
            out_stall_on = (ph != 4);
            set_config(weight, dim);
            foreach (pool[k])
                pool[k] = 16'($urandom);
            span = active_dim();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(0, 9);
                if (roll < 2) begin
                    if ($urandom_range(0, 1) == 0)
                        send_read(6'($urandom_range(0, span - 1)),
                                  6'($urandom_range(0, span - 1)));
                    else
                        send_read(6'($urandom), 6'($urandom));
                end else if (roll < 3) begin
                    send_load(16'($urandom));
                end else begin
                    send_load(pool[$urandom_range(0, 3)]);
                end
            end
        end
        in_idle_on   = 1'b1;
        out_stall_on = 1'b1;
    endtask

    // Back-to-back single-label labelings at the largest weight on entry (0,0).
    task automatic test_max_weight_run();
        quiesce();
        in_idle_on   = 1'b0;
        out_stall_on = 1'b0;
        set_config(16'hFFFF, 7'd1);
        repeat (HEAVY_LOADS)
            send_load(16'($urandom));
        send_read(6'd0, 6'd0);
        send_read(6'd0, 6'd1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_LOAD;
        in_ch.cluster_label = '0;
        in_ch.read_row      = '0;
        in_ch.read_col      = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = REG_MATCH_WEIGHT;
        cfg_ch.wdata        = '0;
        out_ch.ready        = 1'b0;
        reset_model();

        // Hold reset, then release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_basic_labeling();
        test_dim_change();
        test_zero_weight();
        test_random_labelings();
        test_max_weight_run();

        // Wait out every reply, then give the block time to show extras.
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : tb_top

/* sim.f */
rtl/core/coacc_pkg.sv
rtl/core/coacc_if.sv
rtl/core/coacc_front.sv
rtl/core/coacc_queue.sv
rtl/core/coacc_back.sv
rtl/core/coassociation_matrix_accumulator.sv
tb/tb_top.sv
